>>> rtl/idu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idu_pkg: shared types and constants of the image data URL decoder
// Holds the prefix table, the base64 sextet decode, the error codes and the
// request format that passes from the front end to the output side.
// ----------------------------------------------------------------------------
package idu_pkg;

  // Configuration and sizing
  localparam int unsigned MAXB_W          = 27;
  localparam int unsigned COUNT_BITS_DEF  = 27;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [MAXB_W-1:0] MAX_BYTES_RST = 27'd33554432;

  // Prefix table, one string per format, right-justified in PFX_BITS
  localparam int unsigned PFX_CHARS = 23;
  localparam int unsigned PFX_BITS  = PFX_CHARS * 8;
  localparam logic [PFX_BITS-1:0] PFX_TEXT [4] = '{
    "data:image/png;base64,",
    "data:image/jpeg;base64,",
    "data:image/webp;base64,",
    "data:image/gif;base64,"
  };
  localparam logic [4:0] PFX_LEN [4] = '{5'd22, 5'd23, 5'd23, 5'd22};

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Error codes reported in an error result
  typedef enum logic [2:0] {
    ERR_PREFIX   = 3'd0,
    ERR_CHAR     = 3'd1,
    ERR_PAD_DATA = 3'd2,
    ERR_NONCANON = 3'd3,
    ERR_LENGTH   = 3'd4,
    ERR_OVERSIZE = 3'd5
  } idu_err_e;

  // One request from the front end: a closed group or an error report
  typedef struct packed {
    logic        is_err;
    idu_err_e    code;
    logic [1:0]  fmt;
    logic [1:0]  nbytes;
    logic [23:0] word;
    logic        eos;
  } idu_req_t;

  // Character of prefix k at position idx, zero past its end
  function automatic logic [7:0] pfx_char(input logic [1:0] k, input logic [4:0] idx);
    logic [PFX_BITS-1:0] text;
    logic [4:0]          len;
    logic [4:0]          pos;
    text = PFX_TEXT[k];
    len  = PFX_LEN[k];
    pos  = len - 5'd1 - idx;
    if (idx < len) begin
      pfx_char = text[pos*8 +: 8];
    end else begin
      pfx_char = 8'd0;
    end
  endfunction

  // Base64 decode: {valid, sextet}
  function automatic logic [6:0] sextet(input logic [7:0] c);
    logic [7:0] v;
    logic       ok;
    v  = 8'd0;
    ok = 1'b1;
    if (c inside {["A":"Z"]}) begin
      v = c - 8'h41;
    end else if (c inside {["a":"z"]}) begin
      v = c - 8'h61 + 8'd26;
    end else if (c inside {["0":"9"]}) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      ok = 1'b0;
    end
    sextet = {ok, v[5:0]};
  endfunction

endpackage
`default_nettype wire

>>> rtl/image_data_url_base64_decoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// image_data_url_base64_decoder: streaming decoder for base64 image data URLs
// Matches the image prefix, decodes the payload and reports faults.
// ----------------------------------------------------------------------------
// The block takes one URL character per cycle; in_stall_o rises only when the
// request queue (QUEUE_DEPTH entries) is full. Each fourth payload character
// closes a group that yields up to three data results, and the output side
// issues one result per cycle from its output register, so with the output
// taking results a stream runs at one character per cycle. A fault gives one
// error result with end_of_stream set; later characters up to the final one
// give nothing. The max_bytes register is written through cfg_valid_i/
// cfg_data_i, is always ready, and should be written only while the block is
// idle. After reset no clearing pass is needed.
// ----------------------------------------------------------------------------
module image_data_url_base64_decoder #(
  parameter int unsigned COUNT_BITS  = idu_pkg::COUNT_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = idu_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 character_i,
  input  wire logic                       final_char_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            kind_o,
  output logic [7:0]                      data_byte_o,
  output logic [1:0]                      image_format_o,
  output logic [2:0]                      error_code_o,
  output logic                            end_of_stream_o,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [idu_pkg::MAXB_W-1:0] cfg_data_i
);
  import idu_pkg::*;

  logic [MAXB_W-1:0] max_bytes_q;
  idu_req_t          req, head;
  logic              push, pop, full, empty, accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  // Hold the size limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MAX_BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_bytes_q <= cfg_data_i;
    end
  end

  idu_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .character_i  (character_i),
    .final_char_i (final_char_i),
    .max_bytes_i  (max_bytes_q),
    .req_o        (req),
    .push_o       (push)
  );

  idu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (req),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  idu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .data_byte_o     (data_byte_o),
    .image_format_o  (image_format_o),
    .error_code_o    (error_code_o),
    .end_of_stream_o (end_of_stream_o)
  );

endmodule
`default_nettype wire

>>> rtl/idu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idu_front: prefix match and group classification
// Takes one character per cycle while accept_i is high, tracks the prefix and the base64 group, and
// pushes a request when a group closes or a fault is seen.
// ----------------------------------------------------------------------------
module idu_front #(
  parameter int unsigned COUNT_BITS = 27
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       accept_i,
  input  wire logic [7:0]                 character_i,
  input  wire logic                       final_char_i,
  input  wire logic [idu_pkg::MAXB_W-1:0] max_bytes_i,
  output idu_pkg::idu_req_t               req_o,
  output logic                            push_o
);
  import idu_pkg::*;

  localparam int unsigned SUM_W = COUNT_BITS + 1;
  localparam int unsigned CMP_W = (SUM_W > MAXB_W) ? SUM_W : MAXB_W;

  typedef enum logic [2:0] {
    PH_PREFIX  = 3'b001,
    PH_PAYLOAD = 3'b010,
    PH_SKIP    = 3'b100
  } phase_e;

  phase_e                phase_q, phase_d;
  logic [4:0]            idx_q, idx_d;
  logic [3:0]            cand_q, cand_d;
  logic [1:0]            gp_q, gp_d;
  logic [17:0]           held_q, held_d;
  logic                  pad2_q, pad2_d;
  logic [COUNT_BITS-1:0] cnt_q, cnt_d;
  logic [1:0]            fmt_q, fmt_d;

  logic       fire_err, grp;
  idu_err_e   err_code;
  logic [1:0] err_fmt;
  logic [3:0] keep;
  logic       done_any;
  logic [1:0] done_k;
  logic [6:0] sx;
  logic       pad;
  logic [1:0] nbytes;
  logic [SUM_W-1:0] sum;
  logic       over;

  // Decode the character and size the group that it would close
  always_comb begin
    sx     = sextet(character_i);
    pad    = (character_i == CHAR_PAD);
    nbytes = 2'd3 - {1'b0, pad} - {1'b0, pad2_q};
    sum    = {1'b0, cnt_q} + SUM_W'(nbytes);
    over   = (CMP_W'(sum) > CMP_W'(max_bytes_i)) || sum[COUNT_BITS];
  end

  // Match the character against every live prefix
  always_comb begin
    keep     = '0;
    done_any = 1'b0;
    done_k   = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (cand_q[k] && (idx_q < PFX_LEN[k]) &&
          (pfx_char(2'(k), idx_q) == character_i)) begin
        keep[k] = 1'b1;
        if (idx_q + 5'd1 == PFX_LEN[k]) begin
          done_any = 1'b1;
          done_k   = 2'(k);
        end
      end
    end
  end

  // Classify the character and step the stream state
  always_comb begin
    phase_d  = phase_q;
    idx_d    = idx_q;
    cand_d   = cand_q;
    gp_d     = gp_q;
    held_d   = held_q;
    pad2_d   = pad2_q;
    cnt_d    = cnt_q;
    fmt_d    = fmt_q;
    fire_err = 1'b0;
    grp      = 1'b0;
    err_code = ERR_PREFIX;
    err_fmt  = fmt_q;
    case (phase_q)
      PH_PREFIX: begin
        if (keep == 4'd0) begin
          fire_err = 1'b1;
          err_code = ERR_PREFIX;
        end else if (done_any) begin
          fmt_d   = done_k;
          err_fmt = done_k;
          if (final_char_i) begin
            fire_err = 1'b1;
            err_code = ERR_LENGTH;
          end else begin
            phase_d = PH_PAYLOAD;
            idx_d   = 5'd0;
            cand_d  = 4'hF;
          end
        end else if (final_char_i) begin
          fire_err = 1'b1;
          err_code = ERR_PREFIX;
        end else begin
          cand_d = keep;
          idx_d  = idx_q + 5'd1;
        end
      end
      PH_PAYLOAD: begin
        if (gp_q != 2'd3) begin
          if (final_char_i) begin
            fire_err = 1'b1;
            err_code = ERR_LENGTH;
          end else if (pad && (gp_q != 2'd2)) begin
            fire_err = 1'b1;
            err_code = ERR_CHAR;
          end else if (!pad && !sx[6]) begin
            fire_err = 1'b1;
            err_code = ERR_CHAR;
          end else begin
            pad2_d = pad2_q | pad;
            held_d = {held_q[11:0], pad ? 6'd0 : sx[5:0]};
            gp_d   = gp_q + 2'd1;
          end
        end else begin
          if (!final_char_i && (pad2_q || pad)) begin
            fire_err = 1'b1;
            err_code = ERR_CHAR;
          end else if (!pad && !sx[6]) begin
            fire_err = 1'b1;
            err_code = ERR_CHAR;
          end else if (pad2_q && !pad) begin
            fire_err = 1'b1;
            err_code = ERR_PAD_DATA;
          end else if (pad2_q && (held_q[9:6] != 4'd0)) begin
            fire_err = 1'b1;
            err_code = ERR_NONCANON;
          end else if (pad && !pad2_q && (held_q[1:0] != 2'd0)) begin
            fire_err = 1'b1;
            err_code = ERR_NONCANON;
          end else if (over) begin
            fire_err = 1'b1;
            err_code = ERR_OVERSIZE;
          end else begin
            grp    = 1'b1;
            cnt_d  = sum[COUNT_BITS-1:0];
            gp_d   = 2'd0;
            held_d = 18'd0;
            pad2_d = 1'b0;
          end
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase
    if (fire_err) begin
      phase_d = PH_SKIP;
    end
  end

  // Build the request for the output side
  always_comb begin
    push_o        = accept_i && (fire_err || grp);
    req_o.is_err  = fire_err;
    req_o.code    = err_code;
    req_o.fmt     = fire_err ? err_fmt : fmt_q;
    req_o.nbytes  = nbytes;
    req_o.word    = {held_q, pad ? 6'd0 : sx[5:0]};
    req_o.eos     = final_char_i;
  end

  // Advance the state; the final character returns it to the stream start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      idx_q   <= 5'd0;
      cand_q  <= 4'hF;
      gp_q    <= 2'd0;
      held_q  <= 18'd0;
      pad2_q  <= 1'b0;
      cnt_q   <= '0;
      fmt_q   <= 2'd0;
    end else if (accept_i) begin
      if (final_char_i) begin
        phase_q <= PH_PREFIX;
        idx_q   <= 5'd0;
        cand_q  <= 4'hF;
        gp_q    <= 2'd0;
        held_q  <= 18'd0;
        pad2_q  <= 1'b0;
        cnt_q   <= '0;
        fmt_q   <= 2'd0;
      end else begin
        phase_q <= phase_d;
        idx_q   <= idx_d;
        cand_q  <= cand_d;
        gp_q    <= gp_d;
        held_q  <= held_d;
        pad2_q  <= pad2_d;
        cnt_q   <= cnt_d;
        fmt_q   <= fmt_d;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/idu_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idu_fifo: request queue between front end and output side
// Small register queue; the head entry is always visible to the reader.
// ----------------------------------------------------------------------------
module idu_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire idu_pkg::idu_req_t data_i,
  input  wire logic              pop_i,
  output idu_pkg::idu_req_t      head_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import idu_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  idu_req_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/idu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idu_back: result serializer
// Walks the head request byte by byte into the output register and pops it
// after its last result.
// ----------------------------------------------------------------------------
module idu_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire idu_pkg::idu_req_t head_i,
  input  wire logic              empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic                   kind_o,
  output logic [7:0]             data_byte_o,
  output logic [1:0]             image_format_o,
  output logic [2:0]             error_code_o,
  output logic                   end_of_stream_o
);
  import idu_pkg::*;

  logic [1:0] idx_q;
  logic       valid_q;
  logic       kind_q, eos_q;
  logic [7:0] byte_q;
  logic [1:0] fmt_q;
  logic [2:0] code_q;

  logic       advance, last;
  logic [7:0] sel_byte;

  assign advance = (!valid_q || !out_stall_i) && !empty_i;
  assign last    = head_i.is_err || (idx_q == head_i.nbytes - 2'd1);
  assign pop_o   = advance && last;

  // Pick the next byte of the group
  always_comb begin
    case (idx_q)
      2'd0:    sel_byte = head_i.word[23:16];
      2'd1:    sel_byte = head_i.word[15:8];
      2'd2:    sel_byte = head_i.word[7:0];
      default: sel_byte = 8'd0;
    endcase
  end

  // Hold control: output valid and byte position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      if (!valid_q || !out_stall_i) begin
        valid_q <= !empty_i;
      end
      if (advance) begin
        idx_q <= last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

  // Load the output payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      kind_q <= head_i.is_err;
      byte_q <= head_i.is_err ? 8'd0 : sel_byte;
      fmt_q  <= head_i.fmt;
      code_q <= head_i.is_err ? head_i.code : 3'd0;
      eos_q  <= head_i.is_err || (head_i.eos && last);
    end
  end

  assign out_valid_o     = valid_q;
  assign kind_o          = kind_q;
  assign data_byte_o     = byte_q;
  assign image_format_o  = fmt_q;
  assign error_code_o    = code_q;
  assign end_of_stream_o = eos_q;

endmodule
`default_nettype wire

>>> rtl/idu_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// idu_checker: port-level checks of the data URL decoder
// Watches the input hold and the result fields over time and binds to the top level.
// ----------------------------------------------------------------------------
module idu_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] character_i,
  input wire logic       final_char_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       kind_o,
  input wire logic [7:0] data_byte_o,
  input wire logic [1:0] image_format_o,
  input wire logic [2:0] error_code_o,
  input wire logic       end_of_stream_o
);

  // Hold a stalled request on the input side
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(character_i) &&
      $stable(final_char_i))
    else $error("stalled request changed");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(data_byte_o) &&
      $stable(kind_o) && $stable(error_code_o) && $stable(end_of_stream_o) &&
      $stable(image_format_o))
    else $error("stalled result changed");

  // Close the stream on every error report, with a zero data byte
  a_err_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> end_of_stream_o && (data_byte_o == 8'd0))
    else $error("error result malformed");

  // Keep the error code zero on data results
  a_data_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kind_o |-> (error_code_o == 3'd0))
    else $error("data result carries an error code");

  // Report only defined error codes
  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o |-> (error_code_o != 3'd6) && (error_code_o != 3'd7))
    else $error("undefined error code");

endmodule

bind image_data_url_base64_decoder idu_checker u_idu_checker (.*);
`default_nettype wire
